/* rtl/oneshot_timer_table_assert.svh */
// Assertion macros shared by the timer table RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ONESHOT_TIMER_TABLE_ASSERT_SVH
`define ONESHOT_TIMER_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ott_pkg.sv */
`default_nettype none

package ott_pkg;

    localparam int KIND_BITS = 2;

    localparam logic [KIND_BITS-1:0] KIND_ARMED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FIRED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_FULL  = 2'd3;

    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

`default_nettype wire

/* rtl/ott_slot_ram.sv */
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module ott_slot_ram #(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4,
    parameter int DATA_BITS = 40
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data only changes on a read, so it holds while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/oneshot_timer_table.sv */
// Table of SLOTS one-shot timers. An arm request (tuser = 0) stores its handle and
// delay in the lowest free slot and returns one "armed" result with that slot, or one
// "full" result when every slot is in use. A tick request (tuser = 1) walks all slots
// in ascending order: each active timer whose remaining time is at most the elapsed
// amount fires (one result with slot and handle, and the slot is freed); the others
// are reduced by the elapsed amount. A tick that fires nothing returns one "none"
// result. The last result of each request has tlast set. Requests are taken one at a
// time. An arm walks up from slot 0 past the occupied slots to the chosen one; a tick
// walks every slot and finishes later when the highest slot holds an active timer,
// since that slot's read is evaluated only after the walk has passed the last slot.
// The walk covers one slot per cycle, reading each active slot of a tick through the
// single read port of the timer memory, and is held up while the result side does
// not take results. No clearing pass is needed after reset.
`default_nettype none

`include "oneshot_timer_table_assert.svh"

module oneshot_timer_table #(
    parameter int SLOTS       = 16,
    parameter int TIME_BITS   = 24,
    parameter int HANDLE_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // handle, amount
    input  wire logic [((HANDLE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    // opcode
    input  wire logic s_axis_tuser,

    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // slot, fired_handle
    output logic [(($clog2(SLOTS)+HANDLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // kind
    output logic [ott_pkg::KIND_BITS-1:0] m_axis_tuser,
    output logic m_axis_tlast
);

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);
    localparam int WORD_BITS = HANDLE_BITS + TIME_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ARM  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;

    localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(SLOTS);

    logic [1:0]             state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]   amt_reg, amt_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [SLOTS-1:0]       active_reg, active_next;

    logic                   eval_valid_reg, eval_valid_next;
    logic [SLOT_BITS-1:0]   eval_idx_reg, eval_idx_next;

    logic                   held_valid_reg, held_valid_next;
    logic [SLOT_BITS-1:0]   held_slot_reg, held_slot_next;
    logic [HANDLE_BITS-1:0] held_hnd_reg, held_hnd_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ott_pkg::KIND_BITS-1:0] out_kind_reg, out_kind_next;
    logic [SLOT_BITS-1:0]        out_slot_reg, out_slot_next;
    logic [HANDLE_BITS-1:0]      out_hnd_reg, out_hnd_next;
    logic                        out_last_reg, out_last_next;

    logic                 ram_wr_en;
    logic [SLOT_BITS-1:0] ram_wr_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [SLOT_BITS-1:0] ram_rd_addr;
    logic [WORD_BITS-1:0] ram_rd_data;

    logic [SLOT_BITS-1:0]   idx;
    logic                   at_end;
    logic                   out_free;
    logic [TIME_BITS-1:0]   rd_rem;
    logic [HANDLE_BITS-1:0] rd_hnd;
    logic                   fire;
    logic                   stall;

    // Each memory word holds the remaining time in the low bits and the handle above.
    ott_slot_ram #(
        .DEPTH     (SLOTS),
        .ADDR_BITS (SLOT_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign idx      = cnt_reg[SLOT_BITS-1:0];
    assign at_end   = (cnt_reg == CNT_END);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_rem   = ram_rd_data[TIME_BITS-1:0];
    assign rd_hnd   = ram_rd_data[TIME_BITS +: HANDLE_BITS];
    assign fire     = (rd_rem <= amt_reg);

    // A fired timer waits in the held register until the walk knows whether it is
    // the last one; a second fire pushes the held one out and must wait for room.
    assign stall = eval_valid_reg && fire && held_valid_reg && !out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        amt_next        = amt_reg;
        hnd_next        = hnd_reg;
        active_next     = active_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_hnd_next   = held_hnd_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_hnd_next    = out_hnd_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = eval_idx_reg;
        ram_wr_data     = {rd_hnd, rd_rem - amt_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    hnd_next   = s_axis_tdata[HANDLE_BITS-1:0];
                    amt_next   = s_axis_tdata[HANDLE_BITS +: TIME_BITS];
                    cnt_next   = '0;
                    state_next = (s_axis_tuser == ott_pkg::OP_TICK) ? ST_TICK : ST_ARM;
                end
            end

            ST_ARM:
            begin
                if (at_end)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = ott_pkg::KIND_FULL;
                        out_slot_next  = '0;
                        out_hnd_next   = '0;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else if (!active_reg[idx])
                begin
                    if (out_free)
                    begin
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = idx;
                        ram_wr_data      = {hnd_reg, amt_reg};
                        active_next[idx] = 1'b1;
                        out_valid_next   = 1'b1;
                        out_kind_next    = ott_pkg::KIND_ARMED;
                        out_slot_next    = idx;
                        out_hnd_next     = hnd_reg;
                        out_last_next    = 1'b1;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_BITS'(1);
                end
            end

            ST_TICK:
            begin
                // Evaluate the slot whose read was issued last; its data holds through a stall.
                if (eval_valid_reg && !stall)
                begin
                    if (fire)
                    begin
                        active_next[eval_idx_reg] = 1'b0;
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ott_pkg::KIND_FIRED;
                            out_slot_next  = held_slot_reg;
                            out_hnd_next   = held_hnd_reg;
                            out_last_next  = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_slot_next  = eval_idx_reg;
                        held_hnd_next   = rd_hnd;
                    end
                    else
                    begin
                        ram_wr_en = 1'b1;
                    end
                end

                // Issue the read of the next slot; it never hits the slot written back.
                if (!stall)
                begin
                    if (!at_end)
                    begin
                        eval_valid_next = active_reg[idx];
                        eval_idx_next   = idx;
                        ram_rd_en       = active_reg[idx];
                        cnt_next        = cnt_reg + CNT_BITS'(1);
                    end
                    else
                    begin
                        eval_valid_next = 1'b0;
                    end
                end

                if (at_end && !eval_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_kind_next = ott_pkg::KIND_FIRED;
                        out_slot_next = held_slot_reg;
                        out_hnd_next  = held_hnd_reg;
                    end
                    else
                    begin
                        out_kind_next = ott_pkg::KIND_NONE;
                        out_slot_next = '0;
                        out_hnd_next  = '0;
                    end
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            active_reg     <= '0;
            eval_valid_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            active_reg     <= active_next;
            eval_valid_reg <= eval_valid_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg       <= amt_next;
        hnd_reg       <= hnd_next;
        eval_idx_reg  <= eval_idx_next;
        held_slot_reg <= held_slot_next;
        held_hnd_reg  <= held_hnd_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_hnd_reg   <= out_hnd_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        m_axis_tdata                            = '0;
        m_axis_tdata[SLOT_BITS-1:0]             = out_slot_reg;
        m_axis_tdata[SLOT_BITS +: HANDLE_BITS]  = out_hnd_reg;
    end

    `OTT_ASSERT_NOW(a_idle_clean, s_axis_tready, !eval_valid_reg && !held_valid_reg,
        "idle with a tick still in progress")
    `OTT_ASSERT_NOW(a_held_in_tick, held_valid_reg || eval_valid_reg, state_reg == ST_TICK,
        "tick pipeline busy outside a tick")
    `OTT_ASSERT_NOW(a_ram_no_overlap, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
        "timer memory read and write hit the same slot")
    `OTT_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "accepted request did not start")
    `OTT_ASSERT_NOW(a_single_arm, m_axis_tvalid && m_axis_tuser == ott_pkg::KIND_ARMED,
        m_axis_tlast, "arm result without last")

endmodule

`default_nettype wire
